FILE: sv/sktbl_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted key/value table: shared types and constants.
// No dependencies.
package sktbl_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int KEY_W        = 32;
	localparam int VAL_W        = 32;
	localparam int COUNT_W      = 5;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_UPDATED  = 3'd1,
		ST_FULL     = 3'd2,
		ST_HIT      = 3'd3,
		ST_MISS     = 3'd4
	} status_t;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_t;

	// contents of one cell as seen by its upper neighbor
	typedef struct packed {
		logic                    valid;
		logic                    lt;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} cell_t;

	// request broadcast to every cell
	typedef struct packed {
		logic                    en;
		logic                    ins;
		logic                    upd;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

endpackage

FILE: sv/sorted_key_value_table.sv
`timescale 1ns / 1ps
// Top level of the sorted key/value table: request register, row of cells,
// result register. Uses sktbl_pkg and sktbl_cell.
//
// Keeps up to CAPACITY pairs in ascending signed key order in a row of cells.
// Every request is registered; once the result register is free, all cells
// compare against the key at once and insert (shifting larger entries up by
// one cell), update or report. One request is in flight at a time; a new one
// is taken once the previous has moved to the result register, which can
// hold a result while the next request is taken. Inserting a new key into a
// full table returns status full and leaves the table unchanged.
module sorted_key_value_table
	import sktbl_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    req_type,
	input  logic signed [KEY_W-1:0] key,
	input  logic signed [VAL_W-1:0] value_in,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [2:0]              status,
	output logic                    found,
	output logic signed [VAL_W-1:0] value_out,
	output logic [COUNT_W-1:0]      entry_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                    req_valid_s1;
	req_t                    req_type_s1;
	logic signed [KEY_W-1:0] req_key_s1;
	logic signed [VAL_W-1:0] req_value_s1;

	logic [CNT_W-1:0]        fill_q;
	logic                    out_valid_q;
	status_t                 status_q;
	logic                    found_q;
	logic signed [VAL_W-1:0] value_out_q;
	logic [COUNT_W-1:0]      count_q;

	cell_t                   link [CAPACITY+1];
	logic [CAPACITY-1:0]     eq;
	cmd_t                    cmd;

	logic                    out_free;
	logic                    fire;
	logic                    hit;
	logic                    full;
	logic                    is_lookup;
	logic signed [VAL_W-1:0] hit_value;
	status_t                 status_d;
	logic [CNT_W-1:0]        fill_d;

	assign in_stall  = req_valid_s1;
	assign out_free  = !out_valid_q || !out_stall;
	assign fire      = req_valid_s1 && out_free;
	assign hit       = |eq;
	assign full      = (fill_q == CNT_W'(CAPACITY));
	assign is_lookup = (req_type_s1 == REQ_LOOKUP);

	assign cmd.en    = fire;
	assign cmd.ins   = !is_lookup && !hit && !full;
	assign cmd.upd   = !is_lookup && hit;
	assign cmd.key   = req_key_s1;
	assign cmd.value = req_value_s1;

	assign link[0] = '{valid: 1'b1, lt: 1'b1, key: '0, value: '0};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sktbl_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.prv    (link[i]),
			.cur    (link[i+1]),
			.eq     (eq[i])
		);
	end

	always_comb begin
		hit_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (eq[i]) begin
				hit_value = hit_value | link[i+1].value;
			end
		end
	end

	always_comb begin
		fill_d = fill_q;
		if (is_lookup) begin
			status_d = hit ? ST_HIT : ST_MISS;
		end else if (hit) begin
			status_d = ST_UPDATED;
		end else if (full) begin
			status_d = ST_FULL;
		end else begin
			status_d = ST_INSERTED;
			fill_d   = fill_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			req_valid_s1 <= 1'b1;
		end else if (fire) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_type_s1  <= req_t'(req_type);
			req_key_s1   <= key;
			req_value_s1 <= value_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				fill_q <= fill_d;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q    <= status_d;
			found_q     <= hit;
			value_out_q <= (is_lookup && hit) ? hit_value : '0;
			count_q     <= COUNT_W'(fill_d);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found       = found_q;
	assign value_out   = value_out_q;
	assign entry_count = count_q;

endmodule

FILE: sv/sktbl_cell.sv
`timescale 1ns / 1ps
// One table slot: holds a key/value pair, compares against the request and
// takes the new pair or its lower neighbor's pair on insert, or the new value on update. Uses sktbl_pkg.
module sktbl_cell
	import sktbl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	input  cell_t prv,
	output cell_t cur,
	output logic  eq
);

	logic                    valid_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [VAL_W-1:0] value_q;
	logic                    lt;
	logic                    at_pos;

	assign lt     = valid_q && (key_q < cmd.key);
	assign eq     = valid_q && (key_q == cmd.key);
	assign at_pos = prv.lt && !lt;

	assign cur = '{valid: valid_q, lt: lt, key: key_q, value: value_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.en && cmd.ins) begin
			valid_q <= valid_q | prv.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.en && cmd.ins) begin
			if (at_pos) begin
				key_q   <= cmd.key;
				value_q <= cmd.value;
			end else if (!lt) begin
				key_q   <= prv.key;
				value_q <= prv.value;
			end
		end else if (cmd.en && cmd.upd && eq) begin
			value_q <= cmd.value;
		end
	end

endmodule
